// ===== hdl/nvi_pkg.sv =====
// Package for the Neville polynomial interpolator.
// Holds sizes, status codes and the sequencer state type; no dependencies.
`timescale 1ns / 1ps
package nvi_pkg;
  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int NUM_W      = 49;
  localparam int DEN_W      = 32;
  localparam int STEP_W     = $clog2(NUM_W);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_COINCIDE = 2'd1;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_INIT_RD,
    S_INIT,
    S_RD1,
    S_RD2,
    S_CHK,
    S_DIV,
    S_SAT,
    S_MUL_HP,
    S_MUL_HO,
    S_WR_UP,
    S_DY_RD,
    S_DY,
    S_FINISH
  } state_t;
endpackage

// ===== hdl/nvi_if.sv =====
// Handshake channels of the interpolator: point items in, result items out.
// Depends on nothing.
`timescale 1ns / 1ps
interface nvi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] query_x;
  logic               last_point;
  modport source (output valid, point_x, point_y, query_x, last_point, input ready);
  modport sink   (input valid, point_x, point_y, query_x, last_point, output ready);
endinterface

interface nvi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interpolated_value;
  logic signed [31:0] error_estimate;
  logic        [1:0]  status;
  modport source (output valid, interpolated_value, error_estimate, status, input ready);
  modport sink   (input valid, interpolated_value, error_estimate, status, output ready);
endinterface

// ===== hdl/nvi_divider.sv =====
// Restoring divider of unsigned magnitudes, one quotient bit per cycle.
// Depends on nvi_pkg.
`timescale 1ns / 1ps
module nvi_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [nvi_pkg::NUM_W-1:0] num,
  input  logic [nvi_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [nvi_pkg::NUM_W-1:0] quo
);
  import nvi_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dsr;
  logic [DEN_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= den;
      quo <= num;
    end else if (busy) begin
      rem <= ge ? DEN_W'(rem_sh - {1'b0, dsr}) : rem_sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end
endmodule

// ===== hdl/neville_polynomial_interpolator.sv =====
// Neville interpolator: loads Q16.16 points into three 16-entry memories and, on the
// item marked last, runs the c/d tableau through one divider and one 32x32 multiplier.
// Point items are accepted back to back while loading. Evaluation first runs the nearest
// search over the n points, then passes each of the n(n-1)/2 tableau entries through
// the 49-step bit-serial divider. Up to 16 points are kept; extra points are dropped
// and flagged. Point items are taken while a finished result waits in the output
// register. Depends on nvi_pkg, nvi_if, nvi_divider.
`timescale 1ns / 1ps
module neville_polynomial_interpolator (
  input  logic      clk,
  input  logic      rst,
  nvi_in_if.sink    in_ch,
  nvi_out_if.source out_ch
);
  import nvi_pkg::*;

  state_t state, state_next;

  logic [31:0] abs_mem [MAX_POINTS];
  logic [31:0] up_mem  [MAX_POINTS];
  logic [31:0] lo_mem  [MAX_POINTS];
  logic [31:0] abs_rd, up_rd, lo_rd;
  logic [IDX_W-1:0] abs_ra, up_ra, lo_ra;

  logic [CNT_W-1:0]   cnt;
  logic               ovf;
  logic               zdiv;
  logic [IDX_W-1:0]   i, m, ns;
  logic [31:0]        best;
  logic signed [31:0] qx;
  logic signed [31:0] a_i;
  logic               w_neg, den_neg;
  logic [32:0]        w_mag;
  logic [31:0]        hp_mag, ho_mag;
  logic               hp_neg, ho_neg;
  logic [31:0]        q_mag;
  logic               q_neg;
  logic [63:0]        prod;
  logic signed [36:0] sum;
  logic [31:0]        dy;
  logic               dy_sel;

  logic               accept;
  logic [CNT_W-1:0]   nm;
  logic signed [32:0] dt_s, w_s, ho_s, hp_s, den_s, dyadd;
  logic [31:0]        dt_mag, den_mag;
  logic               div_start, div_done;
  logic [NUM_W-1:0]   quo;
  logic               out_free;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] t;
    t = v[32] ? 33'(-v) : 33'(v);
    return t[31:0];
  endfunction

  function automatic logic [31:0] scale(input logic [63:0] p64, input logic neg);
    logic [47:0] p;
    p = p64[63:16];
    if (p > 48'h0000_8000_0000) p = 48'h0000_8000_0000;
    if (neg) return 32'(-p[31:0]);
    if (p[31]) return 32'h7FFF_FFFF;
    return p[31:0];
  endfunction

  assign accept   = in_ch.valid && in_ch.ready;
  assign nm       = cnt - {1'b0, m};
  assign out_free = !out_ch.valid || out_ch.ready;
  assign dt_s     = 33'(qx) - 33'($signed(abs_rd));
  assign dt_mag   = mag33(dt_s);
  assign w_s      = 33'($signed(up_rd)) - 33'($signed(lo_rd));
  assign ho_s     = 33'($signed(abs_rd)) - 33'(qx);
  assign hp_s     = 33'($signed(abs_rd)) - 33'(qx);
  assign den_s    = 33'(a_i) - 33'($signed(abs_rd));
  assign den_mag  = mag33(den_s);
  assign dyadd    = 33'($signed(dy_sel ? up_rd : lo_rd));
  assign in_ch.ready = (state == S_LOAD);

  nvi_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({w_mag, 16'h0000}),
    .den   (den_mag),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    abs_ra     = i;
    up_ra      = IDX_W'(i + 1'b1);
    lo_ra      = i;
    div_start  = 1'b0;
    unique case (state)
      S_LOAD: begin
        if (accept && in_ch.last_point) state_next = S_SRCH_RD;
      end
      S_SRCH_RD: state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if ({1'b0, i} == cnt - 1'b1) state_next = S_INIT_RD;
        else                         state_next = S_SRCH_RD;
      end
      S_INIT_RD: up_ra = ns;
      S_INIT: begin
        if (cnt == CNT_W'(1)) state_next = S_FINISH;
        else                  state_next = S_RD1;
      end
      S_RD1: state_next = S_RD2;
      S_RD2: begin
        abs_ra     = IDX_W'(i + m);
        state_next = S_CHK;
      end
      S_CHK: begin
        if (den_s == '0) begin
          state_next = S_FINISH;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: if (div_done) state_next = S_SAT;
      S_SAT:    state_next = S_MUL_HP;
      S_MUL_HP: state_next = S_MUL_HO;
      S_MUL_HO: state_next = S_WR_UP;
      S_WR_UP: begin
        if ({1'b0, i} + 1'b1 < nm) state_next = S_RD1;
        else                       state_next = S_DY_RD;
      end
      S_DY_RD: begin
        up_ra      = ns;
        lo_ra      = IDX_W'(ns - 1'b1);
        state_next = S_DY;
      end
      S_DY: begin
        if ({1'b0, m} + 1'b1 < cnt) state_next = S_RD1;
        else                        state_next = S_FINISH;
      end
      S_FINISH: if (out_free) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
    if (state == S_INIT_RD) state_next = S_INIT;
  end

  always_ff @(posedge clk) begin
    abs_rd <= abs_mem[abs_ra];
    up_rd  <= up_mem[up_ra];
    lo_rd  <= lo_mem[lo_ra];
    if (state == S_LOAD && accept && cnt < CNT_W'(MAX_POINTS)) begin
      abs_mem[cnt[IDX_W-1:0]] <= in_ch.point_x;
      up_mem[cnt[IDX_W-1:0]]  <= in_ch.point_y;
      lo_mem[cnt[IDX_W-1:0]]  <= in_ch.point_y;
    end
    if (state == S_MUL_HO) lo_mem[i] <= scale(prod, hp_neg ^ q_neg);
    if (state == S_WR_UP)  up_mem[i] <= scale(prod, ho_neg ^ q_neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      ovf  <= 1'b0;
      zdiv <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (cnt < CNT_W'(MAX_POINTS)) cnt <= cnt + 1'b1;
            else                          ovf <= 1'b1;
            zdiv <= 1'b0;
          end
        end
        S_CHK: if (den_s == '0) zdiv <= 1'b1;
        S_FINISH: begin
          if (out_free) begin
            out_ch.valid <= 1'b1;
            cnt <= '0;
            ovf <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        if (accept) begin
          qx <= in_ch.query_x;
          i  <= '0;
        end
      end
      S_SRCH_CMP: begin
        if (i == '0 || dt_mag < best) begin
          best <= dt_mag;
          ns   <= i;
        end
        i <= IDX_W'(i + 1'b1);
      end
      S_INIT: begin
        dy  <= up_rd;
        sum <= 37'($signed(up_rd));
        m   <= IDX_W'(1);
        i   <= '0;
      end
      S_RD2: begin
        a_i    <= $signed(abs_rd);
        ho_mag <= mag33(ho_s);
        ho_neg <= ho_s[32];
        w_neg  <= w_s[32];
        w_mag  <= w_s[32] ? 33'(-w_s) : 33'(w_s);
      end
      S_CHK: begin
        hp_mag  <= mag33(hp_s);
        hp_neg  <= hp_s[32];
        den_neg <= den_s[32];
      end
      S_SAT: begin
        if (w_neg ^ den_neg) begin
          q_mag <= (quo > NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000 : quo[31:0];
          q_neg <= (quo != '0);
        end else begin
          q_mag <= (quo > NUM_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[31:0];
          q_neg <= 1'b0;
        end
      end
      S_MUL_HP: prod <= hp_mag * q_mag;
      S_MUL_HO: prod <= ho_mag * q_mag;
      S_WR_UP:  i <= IDX_W'(i + 1'b1);
      S_DY_RD:  dy_sel <= ({1'b0, ns, 1'b0} < {1'b0, nm});
      S_DY: begin
        dy  <= dy_sel ? up_rd : lo_rd;
        sum <= sum + 37'(dyadd);
        if (!dy_sel) ns <= IDX_W'(ns - 1'b1);
        m <= IDX_W'(m + 1'b1);
        i <= '0;
      end
      S_FINISH: begin
        if (out_free) begin
          if (zdiv) begin
            out_ch.interpolated_value <= '0;
            out_ch.error_estimate     <= '0;
            out_ch.status             <= STATUS_COINCIDE;
          end else begin
            if (sum > 37'sh0_7FFF_FFFF)
              out_ch.interpolated_value <= 32'sh7FFF_FFFF;
            else if (sum < -37'sh0_8000_0000)
              out_ch.interpolated_value <= 32'sh8000_0000;
            else
              out_ch.interpolated_value <= sum[31:0];
            out_ch.error_estimate <= dy;
            out_ch.status         <= ovf ? STATUS_TOO_MANY : STATUS_OK;
          end
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== hdl/nvi_checker.sv =====
// Port-level checks of the interpolator's result channel.
// Depends on nvi_pkg; bound to neville_polynomial_interpolator.
`timescale 1ns / 1ps
module nvi_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value,
  input logic [31:0] err,
  input logic [1:0]  status
);
  import nvi_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(value) && $stable(err) && $stable(status))
    else $error("stalled result item changed");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_COINCIDE |-> value == '0 && err == '0)
    else $error("coincident abscissae result not zero");

  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");
endmodule

bind neville_polynomial_interpolator nvi_checker u_nvi_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .value     (out_ch.interpolated_value),
  .err       (out_ch.error_estimate),
  .status    (out_ch.status)
);

// ===== tb/sv/tb_neville_polynomial_interpolator.sv =====
// Testbench for neville_polynomial_interpolator: drives point items, predicts each
// result with a Q16.16 Neville tableau predictor or takes it from a directed row,
// checks every output item. Depends on nvi_pkg, nvi_if and the interpolator RTL.
`timescale 1ns / 1ps
module tb_neville_polynomial_interpolator;
  import nvi_pkg::*;

  typedef struct {
    logic signed [31:0] value;
    logic signed [31:0] err_est;
    logic [1:0]         status;
  } interp_result_t;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] qx;
    bit                 last;
    bit                 typed;
    logic signed [31:0] value;
    logic signed [31:0] err_est;
    logic [1:0]         status;
  } point_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nvi_in_if  in_ch ();
  nvi_out_if out_ch ();

  neville_polynomial_interpolator uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  logic signed [31:0] xs [MAX_POINTS];
  logic signed [31:0] c_col [MAX_POINTS];
  logic signed [31:0] d_col [MAX_POINTS];
  int unsigned        n_points;
  bit                 dropped;

  interp_result_t pending_results [$];
  int             mismatches;
  int             send_idle_pct;
  int             recv_idle_pct;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] scale_q16(longint h, logic signed [31:0] q);
    longint unsigned a, b, p;
    bit neg;
    a = (h < 0) ? -h : h;
    b = (q < 0) ? -longint'(q) : longint'(q);
    p = (a * b) >> 16;
    neg = (h < 0) != (q < 0);
    if (p > 64'h80000000) p = 64'h80000000;
    return neg ? clamp32(-longint'(p)) : clamp32(longint'(p));
  endfunction

  function automatic interp_result_t evaluate(logic signed [31:0] x);
    interp_result_t r;
    int unsigned ns, nm;
    longint best, dt, ho, hp, w, den, sum;
    logic signed [31:0] dy, q;
    ns = 1;
    best = longint'(x) - longint'(xs[0]);
    if (best < 0) best = -best;
    for (int unsigned i = 1; i < n_points; i++) begin
      dt = longint'(x) - longint'(xs[i]);
      if (dt < 0) dt = -dt;
      if (dt < best) begin
        best = dt;
        ns = i + 1;
      end
    end
    dy = c_col[ns - 1];
    sum = dy;
    ns--;
    for (int unsigned m = 1; m < n_points; m++) begin
      nm = n_points - m;
      for (int unsigned i = 0; i < nm; i++) begin
        ho = longint'(xs[i]) - longint'(x);
        hp = longint'(xs[i + m]) - longint'(x);
        w = longint'(c_col[i + 1]) - longint'(d_col[i]);
        den = ho - hp;
        if (den == 0) begin
          r.value = 0;
          r.err_est = 0;
          r.status = STATUS_COINCIDE;
          return r;
        end
        q = clamp32((w * 65536) / den);
        d_col[i] = scale_q16(hp, q);
        c_col[i] = scale_q16(ho, q);
      end
      if (2 * ns < nm) begin
        dy = c_col[ns];
      end else begin
        dy = d_col[ns - 1];
        ns--;
      end
      sum += dy;
    end
    r.value = clamp32(sum);
    r.err_est = dy;
    r.status = dropped ? STATUS_TOO_MANY : STATUS_OK;
    return r;
  endfunction

  task automatic load_point(point_row_t row);
    interp_result_t r;
    if (n_points < MAX_POINTS) begin
      xs[n_points] = row.px;
      c_col[n_points] = row.py;
      d_col[n_points] = row.py;
      n_points++;
    end else begin
      dropped = 1'b1;
    end
    if (row.last) begin
      r = evaluate(row.qx);
      if (row.typed) begin
        r.value = row.value;
        r.err_est = row.err_est;
        r.status = row.status;
      end
      pending_results.push_back(r);
      n_points = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic send_point(point_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.point_x    <= row.px;
    in_ch.point_y    <= row.py;
    in_ch.query_x    <= row.qx;
    in_ch.last_point <= row.last;
    do @(posedge clk); while (!in_ch.ready);
    load_point(row);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_x(bit spread);
    if (spread) return $urandom;
    return 32'(int'($urandom_range(64)) - 32) <<< 16 | 32'($urandom_range(3) << 14);
  endfunction

  task automatic send_random_set(output int sent);
    point_row_t row;
    int n, sel;
    bit spread, dup;
    sel = $urandom_range(99);
    if (sel < 80) n = $urandom_range(5, 1);
    else if (sel < 95) n = $urandom_range(16, 6);
    else n = $urandom_range(20, 17);
    spread = ($urandom_range(1) == 0);
    dup = ($urandom_range(19) == 0) && n > 1;
    for (int k = 0; k < n; k++) begin
      row = '{default: 0};
      row.px = (dup && k == n - 1) ? xs[0] : pick_x(spread);
      row.py = spread ? $urandom : pick_x(1'b0);
      row.qx = pick_x(spread);
      row.last = (k == n - 1);
      send_point(row);
    end
    sent = n;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    interp_result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h err %h status %0d",
                   out_ch.interpolated_value, out_ch.error_estimate, out_ch.status);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.interpolated_value !== exp_r.value ||
            out_ch.error_estimate !== exp_r.err_est || out_ch.status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value %h/%h err %h/%h status %0d/%0d (expected/actual)",
                     exp_r.value, out_ch.interpolated_value, exp_r.err_est,
                     out_ch.error_estimate, exp_r.status, out_ch.status);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("** neville_polynomial_interpolator: FAILED **");
    $finish;
  end

  initial begin
    point_row_t directed [7];
    point_row_t row;
    int sent, total;
    in_ch.valid      = 1'b0;
    in_ch.point_x    = '0;
    in_ch.point_y    = '0;
    in_ch.query_x    = '0;
    in_ch.last_point = 1'b0;
    n_points = 0;
    dropped = 1'b0;
    mismatches = 0;
    send_idle_pct = 27;
    recv_idle_pct = 52;
    directed = '{
      '{32'sh0, 32'sh7FFFFFFF, 32'sh0, 1, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, STATUS_OK},
      '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 1, 1, 32'sh80000000, 32'sh80000000,
        STATUS_OK},
      '{32'sh10000, 32'sh5, 32'sh0, 0, 0, 0, 0, STATUS_OK},
      '{32'sh10000, 32'sh9, 32'sh20000, 1, 1, 0, 0, STATUS_COINCIDE},
      '{32'sh80000000, 32'sh7FFFFFFF, 32'sh0, 0, 0, 0, 0, STATUS_OK},
      '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 0, 0, 0, 0, STATUS_OK},
      '{32'sh0, 32'sh12345678, 32'sh7FFFFFFF, 1, 0, 0, 0, STATUS_OK}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_point(directed[i]);
    for (int k = 0; k < 17; k++) begin
      row = '{default: 0};
      row.px = (k - 8) <<< 16;
      row.py = $urandom;
      row.qx = 32'sh8000;
      row.last = (k == 16);
      send_point(row);
    end
    drain();

    total = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 27 : 0;
      while (total < (phase + 1) * 475) begin
        send_random_set(sent);
        total += sent;
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** neville_polynomial_interpolator: PASSED **");
    end else begin
      $display("** neville_polynomial_interpolator: FAILED **");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/nvi_pkg.sv
hdl/nvi_if.sv
hdl/nvi_divider.sv
hdl/neville_polynomial_interpolator.sv
hdl/nvi_checker.sv
tb/sv/tb_neville_polynomial_interpolator.sv
